// File: hw/rtl/rgd_pkg.sv
// shared types, constants and lookup tables of the diamond glyph span renderer
`default_nettype none
package rgd_pkg;

   // tile geometry and segment limits
   localparam int TILE_ROWS = 8;
   localparam int ROWS_W = $clog2(TILE_ROWS + 1);
   localparam int MAX_SEGS = 32;
   localparam int SEG_W = $clog2(MAX_SEGS);

   // anchor offsets applied at 9-bit width
   localparam logic signed [8:0] ANCHOR_DX = -9'sd3;
   localparam logic signed [8:0] ANCHOR_DY = 9'sd2;

   // run table geometry
   localparam int RUN_TABLE_LEN = 198;
   localparam logic [4:0] RUN_FILL = 5'd31;
   localparam logic [3:0] DIGIT_MAX = 4'd9;

   // first run of each glyph half, indexed by digit * 2 + bottom
   localparam logic [7:0] HALF_START [0:19] = '{
      8'd0, 8'd13, 8'd30, 8'd37, 8'd50, 8'd61, 8'd76, 8'd87, 8'd102, 8'd115,
      8'd128, 8'd139, 8'd152, 8'd159, 8'd76, 8'd176, 8'd185, 8'd159, 8'd185, 8'd115
   };

   // run lengths, alternating transparent and visible
   localparam logic [4:0] RUN_TABLE [0:RUN_TABLE_LEN-1] = '{
      5'd17, 5'd3, 5'd9, 5'd7, 5'd7, 5'd1, 5'd3, 5'd4, 5'd4, 5'd4, 5'd2, 5'd1, 5'd2,
      5'd3, 5'd3, 5'd2, 5'd4, 5'd5, 5'd4, 5'd4, 5'd3, 5'd4, 5'd4, 5'd1, 5'd4, 5'd6,
      5'd5, 5'd6, 5'd1, 5'd5,
      5'd29, 5'd7, 5'd7, 5'd5, 5'd6, 5'd1, 5'd9,
      5'd12, 5'd3, 5'd2, 5'd3, 5'd1, 5'd4, 5'd7, 5'd5, 5'd10, 5'd4, 5'd7, 5'd1, 5'd5,
      5'd17, 5'd3, 5'd12, 5'd4, 5'd11, 5'd4, 5'd3, 5'd5, 5'd2, 5'd1, 5'd2,
      5'd3, 5'd3, 5'd2, 5'd7, 5'd2, 5'd4, 5'd3, 5'd4, 5'd4, 5'd4, 5'd11, 5'd4, 5'd7,
      5'd1, 5'd5,
      5'd17, 5'd3, 5'd12, 5'd4, 5'd11, 5'd4, 5'd4, 5'd4, 5'd2, 5'd1, 5'd2,
      5'd12, 5'd3, 5'd2, 5'd3, 5'd4, 5'd4, 5'd4, 5'd4, 5'd1, 5'd4, 5'd6, 5'd5, 5'd6,
      5'd1, 5'd5,
      5'd17, 5'd3, 5'd9, 5'd4, 5'd10, 5'd1, 5'd4, 5'd3, 5'd4, 5'd4, 5'd2, 5'd1, 5'd2,
      5'd3, 5'd3, 5'd5, 5'd4, 5'd9, 5'd4, 5'd9, 5'd4, 5'd7, 5'd4, 5'd6, 5'd1, 5'd5,
      5'd17, 5'd3, 5'd9, 5'd7, 5'd7, 5'd1, 5'd3, 5'd4, 5'd7, 5'd1, 5'd5,
      5'd3, 5'd3, 5'd5, 5'd4, 5'd2, 5'd3, 5'd4, 5'd4, 5'd4, 5'd9, 5'd6, 5'd5, 5'd12,
      5'd17, 5'd3, 5'd9, 5'd4, 5'd10, 5'd1, 5'd20,
      5'd3, 5'd3, 5'd2, 5'd7, 5'd2, 5'd4, 5'd3, 5'd4, 5'd4, 5'd4, 5'd1, 5'd4, 5'd6,
      5'd5, 5'd6, 5'd1, 5'd5,
      5'd25, 5'd3, 5'd9, 5'd4, 5'd7, 5'd4, 5'd6, 5'd1, 5'd5,
      5'd17, 5'd3, 5'd9, 5'd7, 5'd7, 5'd1, 5'd3, 5'd4, 5'd4, 5'd4, 5'd2, 5'd1, 5'd2
   };

   // diamond mask: start offset and length of each scanline
   localparam logic [2:0] MASK_DX [0:7] = '{3'd7, 3'd5, 3'd3, 3'd1, 3'd0, 3'd2, 3'd4, 3'd6};
   localparam logic [3:0] MASK_LEN [0:7] = '{4'd1, 4'd5, 4'd9, 4'd13, 4'd15, 4'd11, 4'd7, 4'd3};

   // one glyph job handed from the front to the back
   typedef struct packed {
      logic [7:0]        run_start;
      logic signed [8:0] base_x;
      logic signed [8:0] base_y;
      logic [3:0]        color;
   } job_type;

   // queue occupancy seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // back-end status
   typedef struct packed {
      logic busy;
   } back_status_type;

   // run length at a table index, fill value past the end
   function automatic logic [4:0] fetch_run(input logic [7:0] idx);
      logic [4:0] val;
      val = RUN_FILL;
      if (int'(idx) < RUN_TABLE_LEN) begin
         val = RUN_TABLE[idx];
      end
      return val;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/rgd_front.sv
// request front end: digit clamp, glyph half lookup and anchor offsets
`default_nettype none
module rgd_front (
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [23:0]              req_tdata,   // digit_value, anchor_x, anchor_y, paint_color
   input  wire logic                     req_tuser,   // upper_half
   input  wire rgd_pkg::queue_status_type q_status,
   output logic                          q_push,
   output rgd_pkg::job_type              q_job
);

   logic [3:0]        digit;
   logic [3:0]        digit_clamped;
   logic [4:0]        half_idx;
   logic signed [7:0] anchor_x;
   logic signed [7:0] anchor_y;

   // unpack the request
   assign digit    = req_tdata[3:0];
   assign anchor_x = req_tdata[11:4];
   assign anchor_y = req_tdata[19:12];

   // clamp the digit and pick the glyph half
   assign digit_clamped = (digit > rgd_pkg::DIGIT_MAX) ? rgd_pkg::DIGIT_MAX : digit;
   assign half_idx      = {digit_clamped, !req_tuser};

   // build the job
   always_comb begin
      q_job.run_start = rgd_pkg::HALF_START[half_idx];
      q_job.base_x    = 9'(anchor_x) + rgd_pkg::ANCHOR_DX;
      q_job.base_y    = 9'(anchor_y) + rgd_pkg::ANCHOR_DY;
      q_job.color     = req_tdata[23:20];
   end

   // transfer into the queue while it has room
   assign req_tready = !q_status.full;
   assign q_push     = req_tvalid && !q_status.full;

endmodule
`default_nettype wire

// File: hw/rtl/rgd_queue.sv
// two-entry job queue between the front end and the span walker
`default_nettype none
module rgd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_push,
   input  wire rgd_pkg::job_type q_push_job,
   input  wire logic             q_pop,
   output rgd_pkg::job_type      q_head_job,
   output rgd_pkg::queue_status_type q_status
);

   rgd_pkg::job_type slot_ff [0:1];
   rgd_pkg::job_type slot_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   // status and head
   assign q_status.full  = count_ff == 2'd2;
   assign q_status.empty = count_ff == 2'd0;
   assign q_head_job     = slot_ff[rd_ptr_ff];

   assign do_push = q_push && !q_status.full;
   assign do_pop  = q_pop && !q_status.empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
      slot_in   = q_push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/rgd_back.sv
// span walker: lays runs over the diamond mask, one segment per cycle unless the result stalls
`default_nettype none
module rgd_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire rgd_pkg::queue_status_type q_status,
   input  wire rgd_pkg::job_type          q_head_job,
   output logic                           q_pop,
   output rgd_pkg::back_status_type       b_status,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [31:0]                    rsp_tdata,   // span_x, span_y, span_len, span_color
   output logic                           rsp_tuser,   // visible
   output logic                           rsp_tlast
);

   localparam int RW = rgd_pkg::ROWS_W;
   localparam int SW = rgd_pkg::SEG_W;

   // walker state
   logic                 busy_ff, busy_in;
   logic [7:0]           ptr_ff, ptr_in;
   logic [4:0]           run_left_ff, run_left_in;
   logic [RW-1:0]        rows_ff, rows_in;
   logic [4:0]           offset_ff, offset_in;
   logic [3:0]           row_left_ff, row_left_in;
   logic                 paint_ff, paint_in;
   logic [SW-1:0]        seg_ff, seg_in;
   logic signed [8:0]    bx_ff, bx_in;
   logic signed [8:0]    by_ff, by_in;
   logic [3:0]           color_ff, color_in;

   // output register
   logic                 out_valid_ff, out_valid_in;
   logic [8:0]           out_x_ff, out_x_in;
   logic [8:0]           out_y_ff, out_y_in;
   logic [3:0]           out_len_ff, out_len_in;
   logic                 out_vis_ff, out_vis_in;
   logic [3:0]           out_color_ff, out_color_in;
   logic                 out_last_ff, out_last_in;

   // step datapath
   logic                 out_free;
   logic                 step;
   logic [3:0]           step_len;
   logic [3:0]           row_left_rem;
   logic [4:0]           run_left_rem;
   logic [RW-1:0]        rows_inc;
   logic [2:0]           mask_idx;
   logic                 row_end;
   logic                 finished;
   logic                 step_last;
   logic [7:0]           ptr_inc;

   assign out_free = !out_valid_ff || rsp_tready;
   assign step     = busy_ff && out_free;
   assign q_pop    = !busy_ff && !q_status.empty;
   assign b_status.busy = busy_ff;

   // segment length and what is left of run and row
   assign step_len     = (run_left_ff < {1'b0, row_left_ff}) ? run_left_ff[3:0] : row_left_ff;
   assign row_left_rem = row_left_ff - step_len;
   assign run_left_rem = run_left_ff - {1'b0, step_len};
   assign rows_inc     = rows_ff + 1'b1;
   assign mask_idx     = 3'(rows_inc);
   assign row_end      = row_left_rem == 4'd0;
   assign finished     = row_end && (rows_inc == RW'(rgd_pkg::TILE_ROWS));
   assign step_last    = finished || (seg_ff == SW'(rgd_pkg::MAX_SEGS - 1));
   assign ptr_inc      = ptr_ff + 8'd1;

   // next state
   always_comb begin
      busy_in      = busy_ff;
      ptr_in       = ptr_ff;
      run_left_in  = run_left_ff;
      rows_in      = rows_ff;
      offset_in    = offset_ff;
      row_left_in  = row_left_ff;
      paint_in     = paint_ff;
      seg_in       = seg_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      color_in     = color_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_len_in   = out_len_ff;
      out_vis_in   = out_vis_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;

      // load a job from the queue
      if (q_pop) begin
         busy_in     = 1'b1;
         ptr_in      = q_head_job.run_start;
         run_left_in = rgd_pkg::fetch_run(q_head_job.run_start);
         rows_in     = '0;
         offset_in   = 5'(rgd_pkg::MASK_DX[0]);
         row_left_in = rgd_pkg::MASK_LEN[0];
         paint_in    = 1'b0;
         seg_in      = '0;
         bx_in       = q_head_job.base_x;
         by_in       = q_head_job.base_y;
         color_in    = q_head_job.color;
      end

      // emit one segment
      if (step) begin
         out_valid_in = 1'b1;
         out_x_in     = bx_ff + 9'(offset_ff);
         out_y_in     = by_ff + 9'(rows_ff);
         out_len_in   = step_len;
         out_vis_in   = paint_ff;
         out_color_in = color_ff;
         out_last_in  = step_last;
         seg_in       = seg_ff + 1'b1;
         if (step_last) begin
            busy_in = 1'b0;
         end
         // row advance
         if (row_end) begin
            rows_in     = rows_inc;
            offset_in   = 5'(rgd_pkg::MASK_DX[mask_idx]);
            row_left_in = rgd_pkg::MASK_LEN[mask_idx];
         end else begin
            offset_in   = offset_ff + 5'(step_len);
            row_left_in = row_left_rem;
         end
         // run advance
         if (run_left_rem == 5'd0) begin
            ptr_in      = ptr_inc;
            run_left_in = rgd_pkg::fetch_run(ptr_inc);
            paint_in    = !paint_ff;
         end else begin
            run_left_in = run_left_rem;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      run_left_ff  <= run_left_in;
      rows_ff      <= rows_in;
      offset_ff    <= offset_in;
      row_left_ff  <= row_left_in;
      paint_ff     <= paint_in;
      seg_ff       <= seg_in;
      bx_ff        <= bx_in;
      by_ff        <= by_in;
      color_ff     <= color_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_len_ff   <= out_len_in;
      out_vis_ff   <= out_vis_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
   end

   // result channel
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_color_ff, out_len_ff, out_y_ff, out_x_ff};
   assign rsp_tuser  = out_vis_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire

// File: hw/rtl/rle_glyph_diamond_span_renderer.sv
// top level of the diamond tile digit glyph span renderer
//
//   channel  dir  tdata bits (low to high)                      tuser      tlast
//   req_     in   digit_value, anchor_x, anchor_y, paint_color  upper_half -
//   rsp_     out  span_x, span_y, span_len, span_color          visible    last_span
//
// a job is loaded from the queue, then the walker emits one segment per cycle while
// no result is stalled; a glyph half has n segments (8 to 32).
// the two-entry job queue keeps taking requests while the walker works.
// reset clears the queue, the walker and the output register.
// a stalled result holds the walker; a full queue drops req_tready.
`default_nettype none
module rle_glyph_diamond_span_renderer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // digit_value, anchor_x, anchor_y, paint_color
   input  wire logic        req_tuser,   // upper_half
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // span_x, span_y, span_len, span_color, zero pad
   output logic             rsp_tuser,   // visible
   output logic             rsp_tlast    // last_span
);

   rgd_pkg::queue_status_type q_status;
   rgd_pkg::back_status_type  b_status;
   rgd_pkg::job_type          push_job;
   rgd_pkg::job_type          head_job;
   logic                      q_push;
   logic                      q_pop;

   // request classification
   rgd_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   // job queue
   rgd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .q_push     (q_push),
      .q_push_job (push_job),
      .q_pop      (q_pop),
      .q_head_job (head_job),
      .q_status   (q_status)
   );

   // span walker
   rgd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_head_job (head_job),
      .q_pop      (q_pop),
      .b_status   (b_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // every emitted segment covers at least one pixel
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[21:18] != 4'd0)
      else $error("zero length segment");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // with no job in the walker or queue, no new segment appears
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (!b_status.busy && q_status.empty && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("segment without a job");

   // a pop from the queue starts the walker
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> b_status.busy)
      else $error("walker not started after pop");

endmodule
`default_nettype wire
